// ===== src/stq_pkg.sv =====
// Shared types and constants for the sorted task queue.
package stq_pkg;

  localparam int TASK_W    = 4;
  localparam int KEY_IN_W  = 32;
  localparam int OUT_KEY_W = 32;
  localparam int COUNT_W   = 5;

  localparam logic [2:0] ACT_APPEND = 3'd0;
  localparam logic [2:0] ACT_INSERT = 3'd1;
  localparam logic [2:0] ACT_POP    = 3'd2;
  localparam logic [2:0] ACT_PEEK   = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_SHIFT  = 5'b00100,
    ST_TAIL   = 5'b01000,
    ST_FINISH = 5'b10000
  } stq_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic shift;
    logic tail;
    logic rd_ahead;
    logic load_out;
  } stq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic single;
    logic full;
    logic out_free;
  } stq_sts_t;

endpackage

// ===== src/stq_ram.sv =====
// Generic single write port RAM with registered read.
module stq_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/stq_ctrl.sv =====
// Sequencer for the sorted task queue: accept, scan, shift, tail write and result hand-off.
module stq_ctrl #(
  parameter int SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 action,
  input  logic [$clog2(SLOTS+1)-1:0] count,
  input  stq_pkg::stq_sts_t          sts,
  output stq_pkg::stq_cmd_t          cmd,
  output logic [$clog2(SLOTS+1)-1:0] idx
);
  import stq_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);

  stq_state_t    state, state_next;
  logic [CW-1:0] idx_next;
  logic [CW-1:0] last, last_next;

  // hold the input closed during reset and while an action is in flight
  assign in_stall = rst || (state != ST_IDLE);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    last_next  = last;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.accept = 1'b1;
          idx_next   = CW'(1);
          last_next  = count - CW'(1);
          state_next = ST_FINISH;
          case (action)
            ACT_APPEND: begin
              if (!sts.full && !sts.empty) begin
                state_next = ST_TAIL;
                idx_next   = count;
              end
            end
            ACT_INSERT: begin
              if (!sts.full && !sts.empty) begin
                if (sts.single) begin
                  state_next = ST_TAIL;
                  idx_next   = count;
                end else begin
                  state_next = ST_SCAN;
                end
              end
            end
            ACT_POP: begin
              if (!sts.empty && !sts.single) begin
                state_next = ST_SHIFT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan     = 1'b1;
        cmd.rd_ahead = (idx != last);
        idx_next     = idx + CW'(1);
        if (idx == last) begin
          state_next = ST_TAIL;
        end
      end
      ST_SHIFT: begin
        cmd.shift    = 1'b1;
        cmd.rd_ahead = (idx != last);
        idx_next     = idx + CW'(1);
        if (idx == last) begin
          state_next = ST_FINISH;
        end
      end
      ST_TAIL: begin
        cmd.tail   = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // hold the result until the output register can take it
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    last <= last_next;
  end

endmodule

// ===== src/stq_dp.sv =====
// Datapath for the sorted task queue: entry RAM, head and carry registers, result.
module stq_dp #(
  parameter int SLOTS    = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  stq_pkg::stq_cmd_t              cmd,
  input  logic [$clog2(SLOTS+1)-1:0]     idx,
  input  logic [2:0]                     action,
  input  logic [stq_pkg::TASK_W-1:0]     task_id,
  input  logic [stq_pkg::KEY_IN_W-1:0]   sort_key,
  output stq_pkg::stq_sts_t              sts,
  output logic [$clog2(SLOTS+1)-1:0]     count,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic                           out_valid,
  output logic [stq_pkg::TASK_W-1:0]     out_task,
  output logic [stq_pkg::OUT_KEY_W-1:0]  out_key,
  output logic [stq_pkg::COUNT_W-1:0]    entry_count,
  output logic [1:0]                     status
);
  import stq_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);
  localparam int AW = $clog2(SLOTS);
  localparam int EW = KEY_BITS + TASK_W;

  logic [KEY_BITS-1:0] key_in;
  logic [TASK_W-1:0]   head_task, new_task, carry_task, rd_task;
  logic [KEY_BITS-1:0] head_key, new_key, carry_key, rd_key;
  logic                inserted;
  logic                empty, full, single, idx_one, key_le;

  logic [EW-1:0] rd_data, wr_data;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          we, rd_en;

  logic                 pend_valid;
  logic [TASK_W-1:0]    pend_task;
  logic [OUT_KEY_W-1:0] pend_key;
  logic [COUNT_W-1:0]   pend_count;
  logic [1:0]           pend_status;

  logic                 pv_next;
  logic [TASK_W-1:0]    pt_next;
  logic [OUT_KEY_W-1:0] pk_next;
  logic [CW-1:0]        pc_next;
  logic [1:0]           ps_next;

  assign key_in  = KEY_BITS'(sort_key);
  assign empty   = (count == '0);
  assign full    = (count == CW'(SLOTS));
  assign single  = (count == CW'(1));
  assign idx_one = (idx == CW'(1));

  assign sts.empty    = empty;
  assign sts.single   = single;
  assign sts.full     = full;
  assign sts.out_free = !res_valid || !res_stall;

  assign rd_task = rd_data[KEY_BITS +: TASK_W];
  assign rd_key  = rd_data[KEY_BITS-1:0];
  assign key_le  = (new_key <= rd_key);

  stq_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Slot 0 lives in the head registers; the RAM serves slots 1 and up.
  assign rd_en   = cmd.accept || cmd.rd_ahead;
  assign rd_addr = cmd.accept ? AW'(1) : AW'(idx + CW'(1));

  always_comb begin
    we      = 1'b0;
    wr_addr = AW'(idx);
    wr_data = {new_task, new_key};
    if (cmd.scan) begin
      if (inserted) begin
        we      = 1'b1;
        wr_data = {carry_task, carry_key};
      end else if (key_le) begin
        we = 1'b1;
      end
    end
    if (cmd.tail) begin
      we = 1'b1;
      if (inserted) begin
        wr_data = {carry_task, carry_key};
      end
    end
    if (cmd.shift && !idx_one) begin
      we      = 1'b1;
      wr_addr = AW'(idx - CW'(1));
      wr_data = rd_data;
    end
  end

  // Result of the accepted action, known at transfer time
  always_comb begin
    pv_next = !empty;
    pt_next = empty ? '0 : head_task;
    pk_next = empty ? '0 : OUT_KEY_W'(head_key);
    pc_next = count;
    ps_next = STATUS_OK;
    case (action)
      ACT_APPEND, ACT_INSERT: begin
        if (full) begin
          ps_next = STATUS_FULL;
        end else begin
          pc_next = count + CW'(1);
          if (empty || (action == ACT_INSERT && key_in < head_key)) begin
            pv_next = 1'b1;
            pt_next = task_id;
            pk_next = OUT_KEY_W'(key_in);
          end
        end
      end
      ACT_POP: begin
        if (empty) begin
          ps_next = STATUS_EMPTY;
        end else begin
          pc_next = count - CW'(1);
        end
      end
      ACT_PEEK: begin
        if (empty) begin
          ps_next = STATUS_EMPTY;
        end
      end
      ACT_CLEAR: begin
        pv_next = 1'b0;
        pt_next = '0;
        pk_next = '0;
        pc_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      inserted  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        count    <= pc_next;
        inserted <= empty || (action == ACT_INSERT && key_in < head_key);
      end
      if (cmd.scan && !inserted && key_le) begin
        inserted <= 1'b1;
      end
      if (cmd.load_out) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      new_task    <= task_id;
      new_key     <= key_in;
      pend_valid  <= pv_next;
      pend_task   <= pt_next;
      pend_key    <= pk_next;
      pend_count  <= COUNT_W'(pc_next);
      pend_status <= ps_next;
      if ((action == ACT_APPEND || action == ACT_INSERT) && !full) begin
        if (empty) begin
          head_task <= task_id;
          head_key  <= key_in;
        end else if (action == ACT_INSERT && key_in < head_key) begin
          // new head; old head ripples down from slot 1
          carry_task <= head_task;
          carry_key  <= head_key;
          head_task  <= task_id;
          head_key   <= key_in;
        end
      end
    end
    if (cmd.scan && (inserted || key_le)) begin
      carry_task <= rd_task;
      carry_key  <= rd_key;
    end
    if (cmd.shift && idx_one) begin
      head_task <= rd_task;
      head_key  <= rd_key;
    end
    if (cmd.load_out) begin
      out_valid   <= pend_valid;
      out_task    <= pend_task;
      out_key     <= pend_key;
      entry_count <= pend_count;
      status      <= pend_status;
    end
  end

endmodule

// ===== src/sorted_task_queue.sv =====
// Sequence: append writes the tail slot, sorted insert scans the held entries, pop of more
// than one entry shifts them down; peek, clear and empty or full cases go to the result.
// Only one action is in flight at a time; the input stays stalled until its result is staged,
// and the single write port of the entry RAM moves one entry per cycle.
// Reset clears the count, sequencer and result valid; entry contents stay undefined
// and need no clearing pass.
module sorted_task_queue #(
  parameter int SLOTS    = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     action,
  input  logic [stq_pkg::TASK_W-1:0]     task_id,
  input  logic [stq_pkg::KEY_IN_W-1:0]   sort_key,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic                           out_valid,
  output logic [stq_pkg::TASK_W-1:0]     out_task,
  output logic [stq_pkg::OUT_KEY_W-1:0]  out_key,
  output logic [stq_pkg::COUNT_W-1:0]    entry_count,
  output logic [1:0]                     status
);
  import stq_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);

  stq_cmd_t      cmd;
  stq_sts_t      sts;
  logic [CW-1:0] idx;
  logic [CW-1:0] count;

  stq_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .count    (count),
    .sts      (sts),
    .cmd      (cmd),
    .idx      (idx)
  );

  stq_dp #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .idx         (idx),
    .action      (action),
    .task_id     (task_id),
    .sort_key    (sort_key),
    .sts         (sts),
    .count       (count),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .out_valid   (out_valid),
    .out_task    (out_task),
    .out_key     (out_key),
    .entry_count (entry_count),
    .status      (status)
  );

  // one action in flight: a transfer closes the input until the result is staged
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second input transfer while an action is in flight");

  a_full_shows_head: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == STATUS_FULL |-> out_valid)
    else $error("dropped push without a head entry");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == STATUS_EMPTY |-> !out_valid && entry_count == '0)
    else $error("empty status with entries held");

  a_no_entry_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_valid |-> out_task == '0 && out_key == '0)
    else $error("payload not cleared when no entry shown");

endmodule
